/* rtl/ansi_escape_to_hid_key_top_assert.svh */
// assertion macros for the terminal escape decoder checker
// expects clk and rst in scope where a macro is used
`ifndef ANSI_ESCAPE_TO_HID_KEY_TOP_ASSERT_SVH
`define ANSI_ESCAPE_TO_HID_KEY_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define AEHK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aehk check failed: same-cycle implication");

// next-cycle implication, quiet during reset
`define AEHK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aehk check failed: next-cycle implication");

`endif

/* rtl/aehk_pkg.sv */
// package for the terminal escape decoder: types, byte constants, usage table
// no dependencies
package aehk_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] TILDE_BYTE = 8'h7e;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // number of lone escape bursts that arm the debug toggle
  localparam logic [7:0] LONE_ESC_TOGGLE_COUNT = 8'd3;

  // position inside an open escape sequence
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LEAD,
    SEQ_FIRST,
    SEQ_SECOND,
    SEQ_DONE
  } seq_pos_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       burst_end;
  } item_t;

  typedef struct packed {
    logic       is_character;
    logic [7:0] code;
    logic       debug_flag;
  } result_t;

  // terminal byte or packed sequence code to hid usage, 0 when unknown
  function automatic logic [7:0] usage_of(input logic [15:0] c);
    logic [7:0] u;
    case (c)
      16'h0008: u = 8'h2a;  // backspace
      16'h0009: u = 8'h2b;  // tab
      16'h000a: u = 8'h28;  // enter
      16'h000d: u = 8'h28;  // enter
      16'h001b: u = 8'h29;  // escape
      16'h0032: u = 8'h49;  // insert
      16'h0033: u = 8'h4c;  // delete
      16'h0041: u = 8'h52;  // up
      16'h0042: u = 8'h51;  // down
      16'h0043: u = 8'h4f;  // right
      16'h0044: u = 8'h50;  // left
      16'h0031: u = 8'h4a;  // home
      16'h0034: u = 8'h4d;  // end
      16'h0035: u = 8'h4b;  // page up
      16'h0036: u = 8'h4e;  // page down
      16'h0050: u = 8'h3a;  // f1
      16'h0051: u = 8'h3b;  // f2
      16'h0052: u = 8'h3c;  // f3
      16'h0053: u = 8'h3d;  // f4
      16'h3136: u = 8'h3e;  // f5
      16'h3137: u = 8'h3f;  // f6
      16'h3138: u = 8'h40;  // f7
      16'h3139: u = 8'h41;  // f8
      16'h3230: u = 8'h42;  // f9
      16'h3231: u = 8'h43;  // f10
      16'h3233: u = 8'h44;  // f11
      16'h3234: u = 8'h45;  // f12
      default:  u = 8'h00;
    endcase
    return u;
  endfunction

endpackage

/* rtl/aehk_in_stage.sv */
// input register of the terminal escape decoder
// depends on aehk_pkg
module aehk_in_stage import aehk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       burst_end,
  input  logic       advance,
  output logic       held_valid,
  output item_t      held
);

  logic load;

  // take a new transaction when empty or when the held one moves on
  assign in_stall = held_valid && !advance;
  assign load     = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held.rx_byte   <= rx_byte;
      held.burst_end <= burst_end;
    end
  end

endmodule

/* rtl/aehk_decode.sv */
// sequence state and per-byte decode of the terminal escape decoder
// depends on aehk_pkg
module aehk_decode import aehk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  seq_pos_t    seq_pos;
  seq_pos_t    pos_step;
  seq_pos_t    seq_pos_next;
  logic [15:0] seq_code;
  logic [15:0] code_step;
  logic [15:0] seq_code_next;
  logic [7:0]  esc_count;
  logic [7:0]  count_step;
  logic [7:0]  esc_count_next;
  logic        debug_on;
  logic        debug_on_next;
  logic        in_seq;
  logic        toggle;
  logic [7:0]  key;
  logic [7:0]  b;
  logic        last;

  assign b    = item.rx_byte;
  assign last = item.burst_end;

  // sequence position after this byte
  always_comb begin
    case (seq_pos)
      SEQ_IDLE:   pos_step = (b == ESC_BYTE) ? SEQ_LEAD : SEQ_IDLE;
      SEQ_LEAD:   pos_step = SEQ_FIRST;
      SEQ_FIRST:  pos_step = SEQ_SECOND;
      SEQ_SECOND: pos_step = (b != TILDE_BYTE) ? SEQ_DONE : SEQ_SECOND;
      SEQ_DONE:   pos_step = SEQ_DONE;
      default:    pos_step = SEQ_IDLE;
    endcase
    seq_pos_next = last ? SEQ_IDLE : pos_step;
  end

  // code packing, escape count, result
  always_comb begin
    code_step  = seq_code;
    count_step = esc_count;
    case (seq_pos)
      SEQ_IDLE: begin
        if (b == ESC_BYTE) begin
          count_step = esc_count + 8'd1;
        end
      end
      SEQ_LEAD: begin
        count_step = 8'd0;
      end
      SEQ_FIRST: begin
        code_step = {8'h00, b};
      end
      SEQ_SECOND: begin
        if (b != TILDE_BYTE) begin
          code_step = {seq_code[7:0], b};
        end
      end
      default: begin
        code_step = seq_code;
      end
    endcase

    in_seq = pos_step inside {SEQ_FIRST, SEQ_SECOND, SEQ_DONE};
    toggle = !in_seq && (count_step == LONE_ESC_TOGGLE_COUNT) && (b == SPACE_BYTE);
    key    = toggle ? 8'h00 : b;

    seq_code_next  = last ? 16'h0000 : code_step;
    esc_count_next = (last && !in_seq && key != ESC_BYTE) ? 8'd0 : count_step;
    debug_on_next  = debug_on ^ (last && toggle);

    res.debug_flag = debug_on_next;
    if (in_seq) begin
      res.is_character = 1'b0;
      res.code         = usage_of(code_step);
    end else if (key < SPACE_BYTE) begin
      res.is_character = 1'b0;
      res.code         = usage_of({8'h00, key});
    end else begin
      res.is_character = 1'b1;
      res.code         = key;
    end
  end

  // state update on each decoded transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_pos   <= SEQ_IDLE;
      seq_code  <= 16'h0000;
      esc_count <= 8'd0;
      debug_on  <= 1'b0;
    end else if (fire) begin
      seq_pos   <= seq_pos_next;
      seq_code  <= seq_code_next;
      esc_count <= esc_count_next;
      debug_on  <= debug_on_next;
    end
  end

endmodule

/* rtl/aehk_out_stage.sv */
// result register of the terminal escape decoder
// depends on aehk_pkg
module aehk_out_stage import aehk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_character,
  output logic [7:0] code,
  output logic       debug_flag
);

  result_t held;

  // free when empty or when the waiting result leaves this cycle
  assign ready = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign is_character = held.is_character;
  assign code         = held.code;
  assign debug_flag   = held.debug_flag;

endmodule

/* rtl/ansi_escape_to_hid_key_top.sv */
// Terminal escape decoder: serial terminal bytes in, hid key usages or characters out.
// Input channel: rx_byte with burst_end, handshake in_valid / in_stall.
// Output channel: is_character, code, debug_flag, handshake out_valid / out_stall.
// A transaction is taken at a clock edge with valid high and stall low.
// Only a byte with burst_end set gives a result; other bytes just advance the
// escape sequence state and give nothing.
// A closing byte passes through the input register, then the result register,
// before it shows on the output. Throughput: one byte per cycle while no
// closing byte waits on a stalled result; the sequence state updates as each
// byte leaves the input register.
// When the receiver stalls, the result waits in the result register and the
// next closing byte waits in the input register; a byte with no result still
// passes through. in_stall rises only while both registers are full.
// Reset (rst, synchronous) empties both registers, closes any open sequence
// and clears the escape count and the debug flag.
// depends on aehk_pkg, aehk_in_stage, aehk_decode, aehk_out_stage
module ansi_escape_to_hid_key_top import aehk_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       burst_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_character,
  output logic [7:0] code,
  output logic       debug_flag
);

  logic    held_valid;
  item_t   held;
  logic    advance;
  logic    out_ready;
  result_t res;

  // held byte moves on unless it closes a burst and the result register is busy
  assign advance = held_valid && (!held.burst_end || out_ready);

  aehk_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .burst_end  (burst_end),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  aehk_decode u_dec (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (held),
    .res  (res)
  );

  aehk_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && held.burst_end),
    .res          (res),
    .ready        (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_character (is_character),
    .code         (code),
    .debug_flag   (debug_flag)
  );

endmodule

/* rtl/aehk_checker.sv */
// port-level checks for the terminal escape decoder, bound to the top level
// depends on aehk_pkg and ansi_escape_to_hid_key_top_assert.svh
`include "ansi_escape_to_hid_key_top_assert.svh"

module aehk_checker import aehk_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       burst_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_character,
  input logic [7:0] code,
  input logic       debug_flag
);

  // a stalled result stays put
  `AEHK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(code) && $stable(is_character) && $stable(debug_flag))

  // input back-pressure only comes from a full, stalled output
  `AEHK_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // characters are never below the space byte
  `AEHK_ASSERT_NOW(a_char_range, out_valid && is_character, code >= SPACE_BYTE)

  // a closing byte taken with no result waiting passes both registers to out_valid
  `AEHK_ASSERT_NEXT(a_latency, in_valid && !in_stall && burst_end && !out_valid, ##1 out_valid)

endmodule

bind ansi_escape_to_hid_key_top aehk_checker u_aehk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .burst_end    (burst_end),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_character (is_character),
  .code         (code),
  .debug_flag   (debug_flag)
);

/* tb/tb_top.sv */
// testbench for the terminal escape decoder: directed table, then random bursts
// depends on aehk_pkg and ansi_escape_to_hid_key_top; checks every result against the table or its own decoder
`timescale 1ns / 100ps

module tb_top;
  import aehk_pkg::*;

  localparam int TOTAL_BYTES = 1200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS = 26;

  localparam logic [7:0] CSI_BYTE = 8'h5b;  // '['
  localparam logic [7:0] SS3_BYTE = 8'h4f;  // 'O'

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [7:0] rx;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // lone bytes: extremes, enter
    {8'h00, 1'b1, 1'b1, {1'b0, 8'h00, 1'b0}},
    {8'hff, 1'b1, 1'b1, {1'b1, 8'hff, 1'b0}},
    {8'h0d, 1'b1, 1'b1, {1'b0, 8'h28, 1'b0}},
    // stray byte before the escape, then cursor up
    {8'h78, 1'b0, 1'b0, 10'h000},
    {ESC_BYTE, 1'b0, 1'b0, 10'h000},
    {CSI_BYTE, 1'b0, 1'b0, 10'h000},
    {8'h41, 1'b1, 1'b0, 10'h000},
    // two-byte code with tilde
    {ESC_BYTE, 1'b0, 1'b0, 10'h000},
    {CSI_BYTE, 1'b0, 1'b0, 10'h000},
    {8'h31, 1'b0, 1'b0, 10'h000},
    {8'h36, 1'b0, 1'b0, 10'h000},
    {TILDE_BYTE, 1'b1, 1'b0, 10'h000},
    // single-shift function key
    {ESC_BYTE, 1'b0, 1'b0, 10'h000},
    {SS3_BYTE, 1'b0, 1'b0, 10'h000},
    {8'h50, 1'b1, 1'b0, 10'h000},
    // over-long sequence, trailing bytes ignored
    {ESC_BYTE, 1'b0, 1'b0, 10'h000},
    {CSI_BYTE, 1'b0, 1'b0, 10'h000},
    {8'h32, 1'b0, 1'b0, 10'h000},
    {8'h34, 1'b0, 1'b0, 10'h000},
    {TILDE_BYTE, 1'b0, 1'b0, 10'h000},
    {8'h7a, 1'b1, 1'b0, 10'h000},
    // three lone escapes then a space flip debug on
    {ESC_BYTE, 1'b1, 1'b1, {1'b0, 8'h29, 1'b0}},
    {ESC_BYTE, 1'b1, 1'b1, {1'b0, 8'h29, 1'b0}},
    {ESC_BYTE, 1'b1, 1'b1, {1'b0, 8'h29, 1'b0}},
    {SPACE_BYTE, 1'b1, 1'b1, {1'b0, 8'h00, 1'b1}},
    // sequence closed right after its lead byte
    {ESC_BYTE, 1'b0, 1'b0, 10'h000}
  };

  localparam logic [7:0] SINGLE_KEYS [14] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h31, 8'h32, 8'h33,
    8'h34, 8'h35, 8'h36, 8'h50, 8'h51, 8'h52, 8'h53
  };
  localparam logic [15:0] FKEY_PAIRS [8] = '{
    16'h3136, 16'h3137, 16'h3138, 16'h3139, 16'h3230, 16'h3231, 16'h3233, 16'h3234
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       burst_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_character;
  logic [7:0] code;
  logic       debug_flag;

  // decoder state mirrored by the testbench
  seq_pos_t    open_pos = SEQ_IDLE;
  logic [15:0] packed_code = '0;
  logic [7:0]  last_rx = '0;
  logic [7:0]  esc_run = '0;
  logic        debug_mode = 1'b0;

  result_t     expected_keys [$];
  logic [7:0]  burst_bytes [$];
  result_t     got_key;
  result_t     want_key;
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          cycle_count = 0;
  int          tx_quiet = 0;
  int          rx_quiet = 0;
  bit          hold_req = 1'b0;

  ansi_escape_to_hid_key_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .burst_end    (burst_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_character (is_character),
    .code         (code),
    .debug_flag   (debug_flag)
  );

  always #2 clk = ~clk;

  // terminal byte or packed sequence code to hid usage
  function automatic logic [7:0] hid_usage(input logic [15:0] c);
    case (c)
      16'h0008: return 8'h2a;
      16'h0009: return 8'h2b;
      16'h000a, 16'h000d: return 8'h28;
      16'h001b: return 8'h29;
      16'h0031: return 8'h4a;
      16'h0032: return 8'h49;
      16'h0033: return 8'h4c;
      16'h0034: return 8'h4d;
      16'h0035: return 8'h4b;
      16'h0036: return 8'h4e;
      16'h0041: return 8'h52;
      16'h0042: return 8'h51;
      16'h0043: return 8'h4f;
      16'h0044: return 8'h50;
      // f1 to f4 run on from 0x3a
      16'h0050, 16'h0051, 16'h0052, 16'h0053: return 8'h3a + c[7:0] - 8'h50;
      // f5 to f8 run on from 0x3e
      16'h3136, 16'h3137, 16'h3138, 16'h3139: return 8'h3e + c[7:0] - 8'h36;
      16'h3230: return 8'h42;
      16'h3231: return 8'h43;
      16'h3233: return 8'h44;
      16'h3234: return 8'h45;
      default: return 8'h00;
    endcase
  endfunction

  // advance the mirrored decoder by one byte, giving a key when the burst closes
  task automatic decode_terminal_byte(input logic [7:0] b, input logic e,
                                      output bit gives, output result_t r);
    logic [7:0] k;
    gives = 1'b0;
    r = '0;
    case (open_pos)
      SEQ_IDLE: begin
        if (b == ESC_BYTE) begin
          open_pos = SEQ_LEAD;
          esc_run = esc_run + 8'd1;
        end
      end
      SEQ_LEAD: begin
        open_pos = SEQ_FIRST;
        esc_run = '0;
      end
      SEQ_FIRST: begin
        packed_code = {8'h00, b};
        open_pos = SEQ_SECOND;
      end
      SEQ_SECOND: begin
        if (b != TILDE_BYTE) begin
          packed_code = {packed_code[7:0], b};
          open_pos = SEQ_DONE;
        end
      end
      default: open_pos = SEQ_DONE;
    endcase
    last_rx = b;
    if (e) begin
      gives = 1'b1;
      if (open_pos > SEQ_LEAD) begin
        r.code = hid_usage(packed_code);
      end else begin
        k = last_rx;
        // armed escape count plus space flips debug and sends no key
        if (esc_run == LONE_ESC_TOGGLE_COUNT && k == SPACE_BYTE) begin
          debug_mode = ~debug_mode;
          k = '0;
        end
        if (k != ESC_BYTE) esc_run = '0;
        if (k < SPACE_BYTE) begin
          r.code = hid_usage({8'h00, k});
        end else begin
          r.is_character = 1'b1;
          r.code = k;
        end
      end
      r.debug_flag = debug_mode;
      open_pos = SEQ_IDLE;
      packed_code = '0;
    end
  endtask

  // mostly no gap, often a short one, now and then a long one
  function automatic int draw_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) quiet = 60;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("%0t: %s: expected %0h, got %0h", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  // offer one byte until taken, then queue the key it should produce
  task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                           input result_t typed_want);
    int gap;
    bit gives;
    result_t guess;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    burst_end <= e;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    decode_terminal_byte(b, e, gives, guess);
    if (gives) expected_keys.push_back(typed ? typed_want : guess);
  endtask

  task automatic send_burst();
    foreach (burst_bytes[i]) send_byte(burst_bytes[i], i == burst_bytes.size() - 1, 1'b0, '0);
    burst_bytes.delete();
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_keys.size() != 0);
  endtask

  // one random burst: mostly well-formed sequences, plus lone escapes, keys and noise
  task automatic build_random_burst();
    int kind;
    int n;
    logic [15:0] pair;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 2)) burst_bytes.push_back(8'($urandom_range(0, 255)));
      end
      burst_bytes.push_back(ESC_BYTE);
      n = $urandom_range(0, 9);
      burst_bytes.push_back(n < 5 ? CSI_BYTE : (n < 9 ? SS3_BYTE : 8'($urandom_range(0, 255))));
      n = $urandom_range(0, 9);
      if (n < 4) begin
        burst_bytes.push_back(SINGLE_KEYS[$urandom_range(0, 13)]);
      end else if (n < 7) begin
        pair = FKEY_PAIRS[$urandom_range(0, 7)];
        burst_bytes.push_back(pair[15:8]);
        burst_bytes.push_back(pair[7:0]);
        if ($urandom_range(0, 1) == 1) burst_bytes.push_back(TILDE_BYTE);
      end else if (n < 9) begin
        repeat ($urandom_range(1, 2)) burst_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // open sequence closed early or tilde in the second place
        if ($urandom_range(0, 1) == 1) begin
          burst_bytes.push_back(8'($urandom_range(0, 255)));
          burst_bytes.push_back(TILDE_BYTE);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) burst_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind < 70) begin
      // lone escapes, sometimes the wrong number, then space or another byte
      repeat ($urandom_range(2, 4)) begin
        burst_bytes.push_back(ESC_BYTE);
        send_burst();
      end
      burst_bytes.push_back($urandom_range(0, 9) < 7 ? SPACE_BYTE : 8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      n = $urandom_range(0, 2);
      burst_bytes.push_back(n == 0 ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) burst_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_burst();
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int len;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        len = draw_gap(rx_quiet);
        out_stall <= (len != 0);
        repeat (len == 0 ? $urandom_range(1, 6) : len) @(posedge clk);
      end
    end
  end

  // check each result transaction against the oldest expected key
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_key = '{is_character: is_character, code: code, debug_flag: debug_flag};
      if (expected_keys.size() == 0) begin
        report_mismatch("result with nothing expected", 0, int'(got_key));
      end else begin
        want_key = expected_keys.pop_front();
        if (got_key.is_character !== want_key.is_character)
          report_mismatch("is_character", int'(want_key.is_character),
                          int'(got_key.is_character));
        if (got_key.code !== want_key.code)
          report_mismatch("code", int'(want_key.code), int'(got_key.code));
        if (got_key.debug_flag !== want_key.debug_flag)
          report_mismatch("debug_flag", int'(want_key.debug_flag), int'(got_key.debug_flag));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus
  initial begin
    bit held;
    bit wrapped;
    int next_drain;
    held = 1'b0;
    wrapped = 1'b0;
    next_drain = 300;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TABLE[i].rx, DIR_TABLE[i].last, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end
    send_byte(CSI_BYTE, 1'b1, 1'b0, '0);

    // random bursts
    while (bytes_sent < TOTAL_BYTES) begin
      build_random_burst();
      if (!held && bytes_sent > 500) begin
        // receiver holds off while bytes keep coming
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!wrapped && bytes_sent > 800) begin
        // escape count wraps back round to three before the space
        wrapped = 1'b1;
        burst_bytes.push_back(8'h61);
        send_burst();
        repeat (259) begin
          burst_bytes.push_back(ESC_BYTE);
          send_burst();
        end
        burst_bytes.push_back(SPACE_BYTE);
        send_burst();
      end
      if (bytes_sent > next_drain) begin
        next_drain += 300;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
